// ===== sv/tlpq_pkg.sv =====
// Shared types, constants and address helper for the three-level priority job queue.
package tlpq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int LEVELS      = 3;
    localparam int SLOTS       = LEVELS * QUEUE_DEPTH;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W      = $clog2(SLOTS);
    localparam int HANDLE_W    = 32;

    // Stream payload layout
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 104;

    localparam int IN_OP_LSB     = 0;
    localparam int IN_PRIO_LSB   = 2;
    localparam int IN_CB_LSB     = 4;
    localparam int IN_ARG_LSB    = 36;
    localparam int IN_CANCEL_LSB = 68;

    localparam int OUT_STATUS_LSB = 0;
    localparam int OUT_ID_LSB     = 2;
    localparam int OUT_CB_LSB     = 34;
    localparam int OUT_ARG_LSB    = 66;
    localparam int OUT_EMPTY_BIT  = 98;
    localparam int OUT_PAD_W      = OUT_TDATA_W - OUT_EMPTY_BIT - 1;

    // Priority levels
    localparam logic [1:0] LVL_LOW  = 2'd0;
    localparam logic [1:0] LVL_MED  = 2'd1;
    localparam logic [1:0] LVL_HIGH = 2'd2;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // One stored job
    typedef struct packed {
        logic [HANDLE_W-1:0] id;
        logic [HANDLE_W-1:0] callback;
        logic [HANDLE_W-1:0] argument;
    } slot_t;

    // Memory address of entry 'off' places after the head of queue 'level'.
    // off never exceeds QUEUE_DEPTH-1, so one conditional subtract wraps the ring.
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [1:0]        level,
                                                    input logic [IDX_W-1:0]  head,
                                                    input logic [FILL_W-1:0] off);
        logic [FILL_W:0]    sum;
        logic [IDX_W-1:0]   ring;
        logic [ADDR_W-1:0]  base;
        sum = (FILL_W + 1)'(head) + (FILL_W + 1)'(off);
        if (sum >= (FILL_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (FILL_W + 1)'(QUEUE_DEPTH);
        end
        ring = sum[IDX_W-1:0];
        base = ADDR_W'(level) * ADDR_W'(QUEUE_DEPTH);
        return base + ADDR_W'(ring);
    endfunction

    // Priority 3 saturates to the high queue
    function automatic logic [1:0] sat_level(input logic [1:0] prio);
        return (prio > LVL_HIGH) ? LVL_HIGH : prio;
    endfunction

endpackage

// ===== sv/three_level_priority_task_queue.sv =====
// Top level of the three-level strict-priority job queue with cancel.
//
// Three FIFO queues (low, medium, high) of QUEUE_DEPTH jobs each share one
// single-port-read, single-port-write job memory; heads, fills and the id
// counter sit in flip-flops. One request is worked at a time. A push writes
// the job in the execute state; a pop reads the head job through the
// memory's registered read, unless nothing is queued; and a remove walks
// every held entry through the memory's registered read, compares the id
// and writes kept jobs back to close the gap. A new request is taken while
// the previous result still waits on m_tready.
// Ids start at 1 after reset and wrap from 0xFFFFFFFF back to 1.
module three_level_priority_task_queue (
    input  logic                               aclk,
    input  logic                               aresetn,
    // opcode[1:0], priority_req[3:2], task_callback[35:4],
    // task_argument[67:36], cancel_id[99:68], zero pad[103:100]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tlpq_pkg::IN_TDATA_W-1:0]    s_tdata,
    // status[1:0], job_id[33:2], job_callback[65:34],
    // job_argument[97:66], all_empty[98], zero pad[103:99]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tlpq_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import tlpq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_EXEC     = 6'b000010,
        S_POP_WAIT = 6'b000100,
        S_REM_RD   = 6'b001000,
        S_REM_CMP  = 6'b010000,
        S_RESULT   = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    opcode_t                op_reg, op_next;
    logic [1:0]             lvl_reg, lvl_next;
    logic                   pop_none_reg, pop_none_next;
    logic [HANDLE_W-1:0]    cb_reg, cb_next;
    logic [HANDLE_W-1:0]    arg_reg, arg_next;
    logic [HANDLE_W-1:0]    cancel_reg, cancel_next;
    logic [IDX_W-1:0]       head_reg [LEVELS];
    logic [IDX_W-1:0]       head_next [LEVELS];
    logic [FILL_W-1:0]      fill_reg [LEVELS];
    logic [FILL_W-1:0]      fill_next [LEVELS];
    logic [HANDLE_W-1:0]    id_ctr_reg, id_ctr_next;
    logic [FILL_W-1:0]      k_reg, k_next;
    logic [FILL_W-1:0]      kept_reg, kept_next;
    logic                   found_reg, found_next;
    status_t                res_status_reg, res_status_next;
    logic [HANDLE_W-1:0]    res_id_reg, res_id_next;
    logic [HANDLE_W-1:0]    res_cb_reg, res_cb_next;
    logic [HANDLE_W-1:0]    res_arg_reg, res_arg_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Job memory port signals
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    slot_t                  ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    slot_t                  ram_rdata;

    // Request field decode
    opcode_t                in_op;
    logic [1:0]             in_prio;
    logic [1:0]             in_pop_lvl;
    logic                   in_pop_none;
    logic [HANDLE_W-1:0]    id_new;
    logic                   all_empty;

    assign in_op   = opcode_t'(s_tdata[IN_OP_LSB +: 2]);
    assign in_prio = s_tdata[IN_PRIO_LSB +: 2];

    // Highest non-empty queue, taken at acceptance while fills are settled
    always_comb begin
        in_pop_none = 1'b0;
        if (fill_reg[2] != '0) begin
            in_pop_lvl = LVL_HIGH;
        end else if (fill_reg[1] != '0) begin
            in_pop_lvl = LVL_MED;
        end else begin
            in_pop_lvl  = LVL_LOW;
            in_pop_none = (fill_reg[0] == '0);
        end
    end

    // Next id skips zero on wrap
    assign id_new    = (id_ctr_reg == '1) ? HANDLE_W'(1) : id_ctr_reg + HANDLE_W'(1);
    assign all_empty = (fill_reg[0] == '0) && (fill_reg[1] == '0) && (fill_reg[2] == '0);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Sequencer: push, pop and remove (read, compare and write back) through the job memory, then the result
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        lvl_next        = lvl_reg;
        pop_none_next   = pop_none_reg;
        cb_next         = cb_reg;
        arg_next        = arg_reg;
        cancel_next     = cancel_reg;
        id_ctr_next     = id_ctr_reg;
        k_next          = k_reg;
        kept_next       = kept_reg;
        found_next      = found_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_cb_next     = res_cb_reg;
        res_arg_next    = res_arg_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        for (int i = 0; i < LEVELS; i++) begin
            head_next[i] = head_reg[i];
            fill_next[i] = fill_reg[i];
        end
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;

        // Result taken downstream
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next       = in_op;
                    cb_next       = s_tdata[IN_CB_LSB +: HANDLE_W];
                    arg_next      = s_tdata[IN_ARG_LSB +: HANDLE_W];
                    cancel_next   = s_tdata[IN_CANCEL_LSB +: HANDLE_W];
                    pop_none_next = in_pop_none;
                    k_next        = '0;
                    kept_next     = '0;
                    found_next    = 1'b0;
                    case (in_op)
                        OP_PUSH: lvl_next = sat_level(in_prio);
                        OP_POP:  lvl_next = in_pop_lvl;
                        default: lvl_next = LVL_LOW;
                    endcase
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                res_status_next = ST_OK;
                res_id_next     = '0;
                res_cb_next     = '0;
                res_arg_next    = '0;
                state_next      = S_RESULT;
                case (op_reg)
                    OP_PUSH: begin
                        if (fill_reg[lvl_reg] == FILL_W'(QUEUE_DEPTH)) begin
                            res_status_next = ST_FULL;
                        end else begin
                            ram_we             = 1'b1;
                            ram_waddr          = slot_addr(lvl_reg, head_reg[lvl_reg],
                                                           fill_reg[lvl_reg]);
                            ram_wdata.id       = id_new;
                            ram_wdata.callback = cb_reg;
                            ram_wdata.argument = arg_reg;
                            fill_next[lvl_reg] = fill_reg[lvl_reg] + FILL_W'(1);
                            id_ctr_next        = id_new;
                            res_id_next        = id_new;
                        end
                    end
                    OP_POP: begin
                        if (pop_none_reg) begin
                            res_status_next = ST_EMPTY;
                        end else begin
                            ram_raddr = slot_addr(lvl_reg, head_reg[lvl_reg], '0);
                            head_next[lvl_reg] =
                                (head_reg[lvl_reg] == IDX_W'(QUEUE_DEPTH - 1)) ?
                                '0 : head_reg[lvl_reg] + IDX_W'(1);
                            fill_next[lvl_reg] = fill_reg[lvl_reg] - FILL_W'(1);
                            state_next = S_POP_WAIT;
                        end
                    end
                    OP_REMOVE: begin
                        state_next = S_REM_RD;
                    end
                    default: begin
                        state_next = S_RESULT;
                    end
                endcase
            end

            // Popped job arrives from memory
            S_POP_WAIT: begin
                res_id_next  = ram_rdata.id;
                res_cb_next  = ram_rdata.callback;
                res_arg_next = ram_rdata.argument;
                state_next   = S_RESULT;
            end

            // Issue the next read of the current queue, or close the queue out
            S_REM_RD: begin
                if (k_reg < fill_reg[lvl_reg]) begin
                    ram_raddr  = slot_addr(lvl_reg, head_reg[lvl_reg], k_reg);
                    state_next = S_REM_CMP;
                end else begin
                    fill_next[lvl_reg] = kept_reg;
                    k_next             = '0;
                    kept_next          = '0;
                    if (lvl_reg == LVL_HIGH) begin
                        res_status_next = found_reg ? ST_OK : ST_NOT_FOUND;
                        state_next      = S_RESULT;
                    end else begin
                        lvl_next = lvl_reg + 2'd1;
                    end
                end
            end

            // Drop a matching job, write the others down to the kept position
            S_REM_CMP: begin
                if (ram_rdata.id == cancel_reg) begin
                    found_next = 1'b1;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_addr(lvl_reg, head_reg[lvl_reg], kept_reg);
                    ram_wdata = ram_rdata;
                    kept_next = kept_reg + FILL_W'(1);
                end
                k_next     = k_reg + FILL_W'(1);
                state_next = S_REM_RD;
            end

            // Hand the result to the output register once it is free
            S_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{OUT_PAD_W{1'b0}}, all_empty, res_arg_reg,
                                     res_cb_reg, res_id_reg, res_status_reg};
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            id_ctr_reg   <= '0;
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            id_ctr_reg   <= id_ctr_next;
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i] <= head_next[i];
                fill_reg[i] <= fill_next[i];
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        lvl_reg        <= lvl_next;
        pop_none_reg   <= pop_none_next;
        cb_reg         <= cb_next;
        arg_reg        <= arg_next;
        cancel_reg     <= cancel_next;
        k_reg          <= k_next;
        kept_reg       <= kept_next;
        found_reg      <= found_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_cb_reg     <= res_cb_next;
        res_arg_reg    <= res_arg_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // Job memory
    tlpq_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (SLOTS)
    ) u_job_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

endmodule

// ===== sv/tlpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tlpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/tlpq_checker.sv =====
// Port-level assertions for the three-level priority job queue, bound to the top level.
module tlpq_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [tlpq_pkg::IN_TDATA_W-1:0]    s_tdata,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [tlpq_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import tlpq_pkg::*;

    logic [1:0]          r_status;
    logic [HANDLE_W-1:0] r_id;
    logic [HANDLE_W-1:0] r_cb;
    logic [HANDLE_W-1:0] r_arg;
    logic                r_empty;
    logic                in_seen;

    assign r_status = m_tdata[OUT_STATUS_LSB +: 2];
    assign r_id     = m_tdata[OUT_ID_LSB +: HANDLE_W];
    assign r_cb     = m_tdata[OUT_CB_LSB +: HANDLE_W];
    assign r_arg    = m_tdata[OUT_ARG_LSB +: HANDLE_W];
    assign r_empty  = m_tdata[OUT_EMPTY_BIT];
    assign in_seen  = s_tvalid && s_tready;

    // No result may be offered straight after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // An empty pop reports every queue empty and carries no job
    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r_status == ST_EMPTY |->
            r_empty && r_id == '0 && r_cb == '0 && r_arg == '0)
        else $error("empty pop carries a job");

    // Refused pushes and failed removes carry no job
    a_no_job: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (r_status == ST_FULL || r_status == ST_NOT_FOUND) |->
            r_id == '0 && r_cb == '0 && r_arg == '0)
        else $error("failed request carries a job");

    // A request is never taken in the cycle after one was taken
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        in_seen |=> !s_tready)
        else $error("request accepted on consecutive cycles");

endmodule

bind three_level_priority_task_queue tlpq_checker u_tlpq_checker (.*);

// ===== tb/sv/tb_three_level_priority_task_queue.sv =====
// Self-checking testbench for the three-level priority job queue: directed and random requests.
module tb_three_level_priority_task_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import tlpq_pkg::*;

    // Opcode with no operation behind it, and the priority code above the high level
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] LVL_OVER  = 2'd3;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 10;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int IDLE_LIMIT      = 4000;
    // a remove over a completely full set of queues is the slowest request
    localparam int TAIL_CYCLES     = 2 * SLOTS + 20;
    localparam int RANDOM_REQUESTS = 550;
    localparam int QUIET_REQUESTS  = 100;
    localparam int EPISODE_LEN     = 30;

    typedef struct {
        logic [HANDLE_W-1:0] id;
        logic [HANDLE_W-1:0] callback;
        logic [HANDLE_W-1:0] argument;
    } job_rec_t;

    typedef struct {
        status_t             status;
        logic [HANDLE_W-1:0] id;
        logic [HANDLE_W-1:0] callback;
        logic [HANDLE_W-1:0] argument;
        logic                all_empty;
    } job_result_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Idling controls, set by the tests
    bit tx_gaps   = 1'b0;
    bit rx_stalls = 1'b0;
    int hold_off_req = 0;

    int fail_count  = 0;
    int idle_cycles = 0;

    // Predicted contents of each level, oldest job first, and the last id handed out
    job_rec_t            level_jobs[LEVELS][$];
    logic [HANDLE_W-1:0] last_issued_id = '0;
    job_result_t         expected_results[$];

    three_level_priority_task_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // Work out the result of one accepted request and update the predicted queues
    function automatic job_result_t job_queue_predict(input logic [IN_TDATA_W-1:0] req);
        logic [1:0]          op;
        logic [1:0]          level;
        logic [HANDLE_W-1:0] cancel;
        job_rec_t            job;
        job_result_t         res;
        bit                  hit;
        op           = req[IN_OP_LSB +: 2];
        level        = req[IN_PRIO_LSB +: 2];
        job.callback = req[IN_CB_LSB +: HANDLE_W];
        job.argument = req[IN_ARG_LSB +: HANDLE_W];
        cancel       = req[IN_CANCEL_LSB +: HANDLE_W];
        job.id       = '0;
        res.status   = ST_OK;
        res.id       = '0;
        res.callback = '0;
        res.argument = '0;
        hit          = 1'b0;
        // priority above high saturates
        if (level > LVL_HIGH) begin
            level = LVL_HIGH;
        end
        case (op)
            OP_PUSH: begin
                if (level_jobs[level].size() >= QUEUE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // id 0 is skipped on wrap
                    last_issued_id = last_issued_id + HANDLE_W'(1);
                    if (last_issued_id == '0) begin
                        last_issued_id = HANDLE_W'(1);
                    end
                    job.id = last_issued_id;
                    level_jobs[level].insert(level_jobs[level].size(), job);
                    res.id = job.id;
                end
            end
            OP_POP: begin
                res.status = ST_EMPTY;
                for (int lv = LEVELS - 1; lv >= 0; lv--) begin
                    if (res.status == ST_EMPTY && level_jobs[lv].size() != 0) begin
                        job          = level_jobs[lv][0];
                        level_jobs[lv].delete(0);
                        res.id       = job.id;
                        res.callback = job.callback;
                        res.argument = job.argument;
                        res.status   = ST_OK;
                    end
                end
            end
            OP_REMOVE: begin
                // every job carrying the id goes, in every level; order of the rest kept
                for (int lv = 0; lv < LEVELS; lv++) begin
                    for (int k = level_jobs[lv].size() - 1; k >= 0; k--) begin
                        if (level_jobs[lv][k].id == cancel) begin
                            level_jobs[lv].delete(k);
                            hit = 1'b1;
                        end
                    end
                end
                if (!hit) begin
                    res.status = ST_NOT_FOUND;
                end
            end
            default: begin
                // unused opcode: no state change, zero payload
            end
        endcase
        res.all_empty = (level_jobs[0].size() + level_jobs[1].size()
                         + level_jobs[2].size()) == 0;
        return res;
    endfunction

    function automatic void compare_field(input string name,
                                          input logic [HANDLE_W-1:0] want,
                                          input logic [HANDLE_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Accepted requests feed the predictor; each result is checked against the oldest expectation
    always @(posedge aclk) begin : result_check
        job_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_results.insert(expected_results.size(), job_queue_predict(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: m_tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    compare_field("status", HANDLE_W'(want.status),
                                  HANDLE_W'(m_tdata[OUT_STATUS_LSB +: 2]));
                    compare_field("job_id", want.id, m_tdata[OUT_ID_LSB +: HANDLE_W]);
                    compare_field("job_callback", want.callback,
                                  m_tdata[OUT_CB_LSB +: HANDLE_W]);
                    compare_field("job_argument", want.argument,
                                  m_tdata[OUT_ARG_LSB +: HANDLE_W]);
                    compare_field("all_empty", HANDLE_W'(want.all_empty),
                                  HANDLE_W'(m_tdata[OUT_EMPTY_BIT]));
                end
            end
        end
    end

    // Watchdog: too long without any request or result moving ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("three_level_priority_task_queue regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stall bursts, or one long hold-off when a test asks for it
    always begin
        @(posedge aclk);
        if (hold_off_req != 0) begin
            m_tready <= 1'b0;
            repeat (hold_off_req) @(posedge aclk);
            hold_off_req = 0;
        end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offer one request and wait until it is taken; valid stays up for a following request
    task automatic send_request(input logic [1:0] op, input logic [1:0] prio,
                                input logic [HANDLE_W-1:0] cb,
                                input logic [HANDLE_W-1:0] arg,
                                input logic [HANDLE_W-1:0] cancel);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[IN_OP_LSB +: 2]            = op;
        word[IN_PRIO_LSB +: 2]          = prio;
        word[IN_CB_LSB +: HANDLE_W]     = cb;
        word[IN_ARG_LSB +: HANDLE_W]    = arg;
        word[IN_CANCEL_LSB +: HANDLE_W] = cancel;
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [HANDLE_W-1:0] pick_live_id();
        int start;
        int lv;
        start = $urandom_range(0, LEVELS - 1);
        for (int i = 0; i < LEVELS; i++) begin
            lv = (start + i) % LEVELS;
            if (level_jobs[lv].size() != 0) begin
                return level_jobs[lv][$urandom_range(0, level_jobs[lv].size() - 1)].id;
            end
        end
        return $urandom;
    endfunction

    // Empty block: pop, removes and the unused opcode with nothing queued
    task automatic test_empty_queue();
        send_request(OP_POP, LVL_LOW, '0, '0, '0);
        send_request(OP_REMOVE, LVL_LOW, '0, '0, '0);
        send_request(OP_REMOVE, LVL_HIGH, '1, '1, '1);
        send_request(OP_UNUSED, LVL_OVER, '1, '1, '1);
    endtask

    // Strict priority and oldest-first order, with saturation of the top priority code
    task automatic test_priority_order();
        send_request(OP_PUSH, LVL_LOW, '0, '0, '0);
        send_request(OP_PUSH, LVL_MED, '1, '1, '1);
        send_request(OP_PUSH, LVL_HIGH, 32'hA5A5_5A5A, 32'h5A5A_A5A5, '0);
        send_request(OP_PUSH, LVL_OVER, 32'h0123_4567, 32'h89AB_CDEF, '0);
        repeat (5) send_request(OP_POP, LVL_LOW, '0, '0, '0);
    endtask

    // Remove from the middle of a queue, of id zero, of an absent id
    task automatic test_remove();
        repeat (3) send_request(OP_PUSH, LVL_LOW, $urandom, $urandom, '0);
        send_request(OP_PUSH, LVL_HIGH, $urandom, $urandom, '0);
        wait_for_drain();
        send_request(OP_REMOVE, LVL_LOW, '0, '0, level_jobs[0][1].id);
        send_request(OP_REMOVE, LVL_MED, '0, '0, '0);
        send_request(OP_REMOVE, LVL_MED, '0, '0, 32'h8000_0000);
        send_request(OP_UNUSED, LVL_MED, $urandom, $urandom, $urandom);
        repeat (4) send_request(OP_POP, LVL_LOW, '0, '0, '0);
    endtask

    // Long hold-off on results while pushes keep coming: the block stalls, then one level fills
    task automatic test_backpressure();
        tx_gaps      = 1'b0;
        hold_off_req = HOLD_OFF_CYCLES;
        repeat (QUEUE_DEPTH + 4) send_request(OP_PUSH, LVL_MED, $urandom, $urandom, $urandom);
        wait_for_drain();
        tx_gaps = 1'b1;
    endtask

    // Random mix in episodes that lean towards filling or emptying the queues
    task automatic test_random_traffic();
        int push_pct;
        int roll;
        bit quiet;
        push_pct = 70;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            quiet = (n >= RANDOM_REQUESTS - QUIET_REQUESTS);
            if (n % EPISODE_LEN == 0 || n == RANDOM_REQUESTS - QUIET_REQUESTS) begin
                push_pct  = ($urandom_range(0, 1) != 0) ? 70 : 30;
                tx_gaps   = !quiet && ($urandom_range(0, 3) != 0);
                rx_stalls = !quiet && ($urandom_range(0, 3) != 0);
            end
            // sender pause half way through
            if (n == RANDOM_REQUESTS / 2) begin
                wait_for_drain();
            end
            roll = $urandom_range(0, 99);
            if (roll < push_pct) begin
                send_request(OP_PUSH, 2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
            end else if (roll < push_pct + (100 - push_pct) / 2) begin
                send_request(OP_POP, 2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
            end else if (roll < 97) begin
                if ($urandom_range(0, 3) != 0) begin
                    send_request(OP_REMOVE, 2'($urandom_range(0, 3)), $urandom, $urandom,
                                 pick_live_id());
                end else begin
                    send_request(OP_REMOVE, 2'($urandom_range(0, 3)), $urandom, $urandom,
                                 $urandom);
                end
            end else begin
                send_request(OP_UNUSED, 2'($urandom_range(0, 3)), $urandom, $urandom,
                             $urandom);
            end
        end
    endtask

    // Test sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        test_empty_queue();
        test_priority_order();
        test_remove();
        test_backpressure();
        test_random_traffic();
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("three_level_priority_task_queue regression: pass");
        end else begin
            $display("three_level_priority_task_queue regression: fail");
        end
        $finish;
    end

endmodule

// ===== three_level_priority_task_queue.f =====
sv/tlpq_pkg.sv
sv/tlpq_ram.sv
sv/three_level_priority_task_queue.sv
sv/tlpq_checker.sv
tb/sv/tb_three_level_priority_task_queue.sv
